// ===== hdl/twq_pkg.sv =====
package twq_pkg;

    localparam int BINS          = 1024;
    localparam int ITEMS         = 256;
    localparam int BIN_W         = $clog2(BINS);
    localparam int ITEM_W        = $clog2(ITEMS);
    localparam int LINK_W        = ITEM_W + 1;
    localparam int TIME_WIDTH    = 32;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int TICK_W        = 16;
    localparam int QUOT_W        = TIME_WIDTH;
    localparam int QCNT_W        = $clog2(QUOT_W + 1);

    localparam logic [LINK_W-1:0] NIL = LINK_W'(ITEMS);

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_REM = 2'd2,
        CMD_ADV = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_TOO_EARLY  = 3'd2,
        ST_BEYOND     = 3'd3,
        ST_POOL_FULL  = 3'd4,
        ST_BAD_HANDLE = 3'd5,
        ST_BIN_BUSY   = 3'd6
    } status_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

// ===== hdl/timing_wheel_event_queue_unit.sv =====
// Channel  | Signals                                        | Handshake
// command  | cmd, event_time, event_payload, item_handle   | start & !busy
// result   | status, result_handle, result_payload, bin_index | done, one cycle
// config   | cfg_data                                       | cfg_valid & cfg_ready
// Enqueue forms the bit-serial quotient (one bit a cycle); a too early, beyond or pool
// full error ends it there, else it reads the bin head and free list link and puts the
// item at the head of its bin. Dequeue reads the bin head, ends on an empty bin, else
// reads the item's link and frees it; advance reads the bin head only. Remove ends at once
// on a bad handle, else reads the item's own link and bin, then the bin head, and walks
// the bin list item by item when the item does not head its bin. After reset a clearing
// pass empties the bin head memory; busy holds. Memory reads are registered.
// The receiver cannot stall: done marks one cycle of valid result.
module timing_wheel_event_queue_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic [twq_pkg::TIME_WIDTH-1:0]      event_time,
    input  logic [twq_pkg::PAYLOAD_WIDTH-1:0]   event_payload,
    input  logic [twq_pkg::ITEM_W-1:0]          item_handle,
    output logic                                done,
    output logic [2:0]                          status,
    output logic [twq_pkg::ITEM_W-1:0]          result_handle,
    output logic [twq_pkg::PAYLOAD_WIDTH-1:0]   result_payload,
    output logic [twq_pkg::BIN_W-1:0]           bin_index,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [twq_pkg::TICK_W-1:0]          cfg_data
);
    import twq_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_DIV   = 11'b00000000100,
        S_HEAD  = 11'b00000001000,
        S_HWAIT = 11'b00000010000,
        S_LINK  = 11'b00000100000,
        S_LWAIT = 11'b00001000000,
        S_EXEC  = 11'b00010000000,
        S_WALK  = 11'b00100000000,
        S_WWAIT = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    // memories
    logic [LINK_W-1:0]        heads_mem [BINS];
    logic [LINK_W-1:0]        links_mem [ITEMS];
    logic [PAYLOAD_WIDTH-1:0] pay_mem   [ITEMS];
    logic [BIN_W-1:0]         ibin_mem  [ITEMS];
    logic [ITEMS-1:0]         live_reg;

    logic              h_we, l_we, p_we;
    logic [BIN_W-1:0]  h_addr, h_waddr;
    logic [LINK_W-1:0] h_wdata, h_rdata;
    logic [ITEM_W-1:0] l_addr, l_waddr;
    logic [LINK_W-1:0] l_wdata, l_rdata;
    logic [PAYLOAD_WIDTH-1:0] p_rdata;
    logic [BIN_W-1:0]  ib_rdata;

    // control and working registers
    state_t             state_reg, state_next;
    logic [BIN_W-1:0]   clr_reg, clr_next;
    logic [ITEM_W:0]    init_reg, init_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [LINK_W-1:0]  free_reg, free_next;
    logic [BIN_W-1:0]   cur_reg, cur_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [1:0]         cmd_reg;
    logic [PAYLOAD_WIDTH-1:0] event_payload_reg;
    logic [ITEM_W-1:0]  hin_reg;
    logic               neg_reg;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic [LINK_W-1:0]  ptr_reg, ptr_next;
    logic [LINK_W-1:0]  hlink_reg, hlink_next;
    logic [2:0]         status_reg, status_next;
    logic [ITEM_W-1:0]  rh_reg, rh_next;
    logic [PAYLOAD_WIDTH-1:0] rp_reg, rp_next;
    logic [ITEMS-1:0]   live_next;

    always_ff @(posedge clk)
    begin
        if (h_we)
            heads_mem[h_waddr] <= h_wdata;
        h_rdata <= heads_mem[h_addr];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
            links_mem[l_waddr] <= l_wdata;
        l_rdata <= links_mem[l_addr];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pay_mem[l_waddr]  <= event_payload_reg;
            ibin_mem[l_waddr] <= bin_reg;
        end
        p_rdata  <= pay_mem[l_addr];
        ib_rdata <= ibin_mem[l_addr];
    end

    logic [TIME_WIDTH-1:0] mag;
    div_ctl_t div_in, div_out;
    logic [QUOT_W-1:0] quot;

    assign mag = (event_time < now_reg) ? now_reg - event_time : event_time - now_reg;
    assign div_in.start = start && state_reg == S_IDLE && cmd_t'(cmd) == CMD_ENQ;
    assign div_in.done  = 1'b0;

    twq_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (div_in),
        .dividend (mag),
        .divisor  (tick_reg),
        .ctl_out  (div_out),
        .quotient (quot)
    );

    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = state_reg == S_IDLE;
    assign done      = state_reg == S_DONE;
    assign status         = status_reg;
    assign result_handle  = rh_reg;
    assign result_payload = rp_reg;
    assign bin_index      = bin_reg;

    logic [BIN_W:0] bsum;
    assign bsum = {1'b0, cur_reg} + {1'b0, quot[BIN_W-1:0]};

    // sequence each command through memory reads and write-backs
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        init_next   = init_reg;
        tick_next   = tick_reg;
        free_next   = free_reg;
        cur_next    = cur_reg;
        now_next    = now_reg;
        bin_next    = bin_reg;
        ptr_next    = ptr_reg;
        hlink_next  = hlink_reg;
        status_next = status_reg;
        rh_next     = rh_reg;
        rp_next     = rp_reg;
        live_next   = live_reg;
        h_we = 1'b0; h_waddr = bin_reg; h_wdata = NIL; h_addr = bin_reg;
        l_we = 1'b0; l_waddr = ptr_reg[ITEM_W-1:0]; l_wdata = NIL;
        l_addr = ptr_reg[ITEM_W-1:0];
        p_we = 1'b0;
        if (cfg_valid && state_reg == S_IDLE)
            tick_next = (cfg_data == '0) ? TICK_W'(1) : cfg_data;
        case (state_reg)
            S_CLEAR:
            begin
                h_we = 1'b1; h_waddr = clr_reg; h_wdata = NIL;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BIN_W'(BINS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                status_next = ST_OK; rh_next = '0; rp_next = '0; bin_next = '0;
                if (start)
                begin
                    case (cmd_t'(cmd))
                        CMD_ENQ: state_next = S_DIV;
                        CMD_DEQ:
                        begin
                            bin_next = cur_reg;
                            state_next = S_HEAD;
                        end
                        CMD_ADV:
                        begin
                            bin_next = cur_reg;
                            state_next = S_HEAD;
                        end
                        default:
                        begin
                            if (!live_reg[item_handle])
                            begin
                                status_next = ST_BAD_HANDLE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ptr_next = {1'b0, item_handle};
                                state_next = S_LINK;
                            end
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_out.done)
                begin
                    if (neg_reg && quot != '0)
                    begin
                        status_next = ST_TOO_EARLY;
                        state_next = S_DONE;
                    end
                    else if (!neg_reg && quot >= QUOT_W'(BINS))
                    begin
                        status_next = ST_BEYOND;
                        state_next = S_DONE;
                    end
                    else if (free_reg == NIL)
                    begin
                        status_next = ST_POOL_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        if (neg_reg)
                            bin_next = cur_reg;
                        else if (bsum >= (BIN_W+1)'(BINS))
                            bin_next = BIN_W'(bsum - (BIN_W+1)'(BINS));
                        else
                            bin_next = bsum[BIN_W-1:0];
                        ptr_next = free_reg;
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                // read head of bin and link of ptr together
                h_addr = bin_reg;
                state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                hlink_next = h_rdata;
                case (cmd_t'(cmd_reg))
                    CMD_ENQ:
                    begin
                        l_addr = ptr_reg[ITEM_W-1:0];
                        state_next = S_LWAIT;
                    end
                    CMD_DEQ:
                    begin
                        if (h_rdata == NIL)
                        begin
                            status_next = ST_EMPTY;
                            bin_next = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ptr_next = h_rdata;
                            l_addr = h_rdata[ITEM_W-1:0];
                            state_next = S_LWAIT;
                        end
                    end
                    CMD_ADV:
                    begin
                        if (h_rdata != NIL)
                        begin
                            status_next = ST_BIN_BUSY;
                            bin_next = '0;
                        end
                        else
                        begin
                            cur_next = (cur_reg == BIN_W'(BINS - 1)) ? '0 : cur_reg + 1'b1;
                            bin_next = (cur_reg == BIN_W'(BINS - 1)) ? '0 : cur_reg + 1'b1;
                            now_next = now_reg + TIME_WIDTH'(tick_reg);
                        end
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        // remove: hlink holds bin head, compare to handle
                        if (h_rdata == ptr_reg)
                        begin
                            h_we = 1'b1; h_waddr = bin_reg; h_wdata = rp_reg[LINK_W-1:0];
                            state_next = S_EXEC;
                        end
                        else
                        begin
                            l_addr = h_rdata[ITEM_W-1:0];
                            hlink_next = h_rdata;
                            state_next = S_WWAIT;
                        end
                    end
                endcase
            end
            S_LINK:
            begin
                // remove: read own link and bin
                l_addr = ptr_reg[ITEM_W-1:0];
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                case (cmd_t'(cmd_reg))
                    CMD_ENQ:
                    begin
                        free_next = l_rdata;
                        p_we = 1'b1; l_waddr = ptr_reg[ITEM_W-1:0];
                        l_we = 1'b1; l_wdata = hlink_reg;
                        h_we = 1'b1; h_waddr = bin_reg; h_wdata = ptr_reg;
                        live_next[ptr_reg[ITEM_W-1:0]] = 1'b1;
                        rh_next = ptr_reg[ITEM_W-1:0];
                        state_next = S_DONE;
                    end
                    CMD_DEQ:
                    begin
                        h_we = 1'b1; h_waddr = cur_reg; h_wdata = l_rdata;
                        rh_next = ptr_reg[ITEM_W-1:0];
                        rp_next = p_rdata;
                        state_next = S_EXEC;
                    end
                    default:
                    begin
                        // remove: keep own link in rp_reg, own bin in bin_reg
                        rp_next = PAYLOAD_WIDTH'(l_rdata);
                        bin_next = ib_rdata;
                        state_next = S_HEAD;
                    end
                endcase
            end
            S_WALK:
            begin
                l_addr = hlink_reg[ITEM_W-1:0];
                state_next = S_WWAIT;
            end
            S_WWAIT:
            begin
                // hlink_reg is predecessor candidate, l_rdata its link
                if (l_rdata == ptr_reg)
                begin
                    l_we = 1'b1; l_waddr = hlink_reg[ITEM_W-1:0];
                    l_wdata = rp_reg[LINK_W-1:0];
                    state_next = S_EXEC;
                end
                else if (l_rdata == NIL)
                    state_next = S_EXEC;
                else
                begin
                    hlink_next = l_rdata;
                    state_next = S_WALK;
                end
            end
            S_EXEC:
            begin
                // release item onto free list
                l_we = 1'b1; l_waddr = ptr_reg[ITEM_W-1:0]; l_wdata = free_reg;
                free_next = ptr_reg;
                live_next[ptr_reg[ITEM_W-1:0]] = 1'b0;
                if (cmd_t'(cmd_reg) == CMD_REM)
                begin
                    rh_next = ptr_reg[ITEM_W-1:0];
                    rp_next = '0;
                end
                else
                    bin_next = cur_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // free list init sweep shares the link port during clear
        if (state_reg == S_CLEAR && !init_reg[ITEM_W])
        begin
            l_we = 1'b1; l_waddr = init_reg[ITEM_W-1:0];
            l_wdata = LINK_W'(init_reg) + 1'b1;
            init_next = init_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            init_reg  <= '0;
            tick_reg  <= TICK_W'(1);
            free_reg  <= '0;
            cur_reg   <= '0;
            now_reg   <= '0;
            live_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            init_reg  <= init_next;
            tick_reg  <= tick_next;
            free_reg  <= free_next;
            cur_reg   <= cur_next;
            now_reg   <= now_next;
            live_reg  <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == S_IDLE)
        begin
            cmd_reg <= cmd;
            event_payload_reg <= event_payload;
            hin_reg <= item_handle;
            neg_reg <= event_time < now_reg;
        end
        bin_reg    <= bin_next;
        ptr_reg    <= ptr_next;
        hlink_reg  <= hlink_next;
        status_reg <= status_next;
        rh_reg     <= rh_next;
        rp_reg     <= rp_next;
    end

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_free_valid: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= NIL) else $error("free head out of range");
    a_rem_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && cmd_t'(cmd_reg) == CMD_REM)
        |-> ptr_reg[ITEM_W-1:0] == hin_reg) else $error("remove lost its handle");
    a_enq_ok_live: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cmd_t'(cmd_reg) == CMD_ENQ && status_reg == ST_OK)
        |-> live_reg[rh_reg]) else $error("enqueued item not live");

endmodule

// ===== hdl/twq_divider.sv =====
module twq_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  twq_pkg::div_ctl_t               ctl_in,
    input  logic [twq_pkg::TIME_WIDTH-1:0]  dividend,
    input  logic [twq_pkg::TICK_W-1:0]      divisor,
    output twq_pkg::div_ctl_t               ctl_out,
    output logic [twq_pkg::QUOT_W-1:0]      quotient
);
    import twq_pkg::*;

    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [TICK_W:0]   rem_reg, rem_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TICK_W:0]   trial;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[TICK_W-1:0], quot_reg[QUOT_W-1]};
        if (ctl_in.start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = QCNT_W'(QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next  = trial - {1'b0, divisor};
                quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == QCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quotient      = quot_reg;
    assign ctl_out.start = busy_reg;
    assign ctl_out.done  = done_reg;

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_in.start |=> busy_reg) else $error("divider did not start");
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < {1'b0, divisor}) else $error("remainder too big");

endmodule
